FILE: hdl/msl_pkg.sv
`default_nettype none

package msl_pkg;

  localparam int NUM_SERVOS = 9;
  localparam int SERVO_W    = 4;
  localparam int WIDTH_W    = 12;
  localparam int REQ_W      = 2;
  localparam int IDX_W      = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  localparam logic [WIDTH_W-1:0] STEP_RESET = WIDTH_W'(4);

  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET_TARGET = 2'd0,
    REQ_PRESET     = 2'd1,
    REQ_TICK       = 2'd2
  } msl_req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } msl_state_e;

endpackage

`default_nettype wire

FILE: hdl/multi_servo_slew_limiter_core.sv
// Slew limiter for NUM_SERVOS servo pulse widths. A request is taken when start is high and
// busy is low. Set-target, preset and unused codes leave busy low; a preset to a valid servo
// puts one result (last set) on the outputs in the following cycle. A tick holds busy high
// through its walk and flush states: one shared subtract/compare/step unit visits one servo
// per cycle, then the flush state sends the held result. Each moved servo gives one result, one
// cycle wide under strobe_o; results cannot be stalled. The last result of a tick is on the
// outputs in the first cycle with busy low again, so a fresh request may be taken in that cycle.
`default_nettype none

module multi_servo_slew_limiter_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire  [msl_pkg::REQ_W-1:0]    req_type_i,
  input  wire  [msl_pkg::SERVO_W-1:0]  servo_i,
  input  wire  [msl_pkg::WIDTH_W-1:0]  width_value_i,
  input  wire                          cfg_we_i,
  input  wire  [msl_pkg::WIDTH_W-1:0]  cfg_wdata_i,
  output logic                         strobe_o,
  output logic [msl_pkg::SERVO_W-1:0]  servo_out_o,
  output logic [msl_pkg::WIDTH_W-1:0]  pulse_width_o,
  output logic                         last_o
);
  import msl_pkg::*;

  msl_state_e state_q, state_d;
  idx_t       idx_q, idx_d;
  width_t     step_q;
  width_t     cur_q [NUM_SERVOS];
  width_t     tgt_q [NUM_SERVOS];

  // result held back until we know whether another servo moves
  logic       pend_valid_q, pend_valid_d;
  idx_t       pend_idx_q, pend_idx_d;
  width_t     pend_width_q, pend_width_d;

  logic       accept;
  logic       cmd_in_range;
  idx_t       cmd_idx;
  logic       wr_tgt, wr_cur_cmd, wr_cur_walk;
  logic       emit;
  idx_t       emit_idx;
  width_t     emit_width;
  logic       emit_last;

  // shared step unit
  width_t     cur_sel, tgt_sel, step_eff, delta, new_width;
  logic       up, moved, reach;

  assign accept       = start && !busy;
  assign cmd_in_range = {{(32-SERVO_W){1'b0}}, servo_i} < 32'(NUM_SERVOS);
  assign cmd_idx      = IDX_W'(servo_i);

  always_comb begin
    cur_sel   = cur_q[idx_q];
    tgt_sel   = tgt_q[idx_q];
    step_eff  = (step_q == '0) ? WIDTH_W'(1) : step_q;
    up        = tgt_sel > cur_sel;
    delta     = up ? (tgt_sel - cur_sel) : (cur_sel - tgt_sel);
    reach     = delta <= step_eff;
    moved     = cur_sel != tgt_sel;
    if (reach) begin
      new_width = tgt_sel;
    end else if (up) begin
      new_width = cur_sel + step_eff;
    end else begin
      new_width = cur_sel - step_eff;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    pend_width_d = pend_width_q;
    busy         = 1'b1;
    wr_tgt       = 1'b0;
    wr_cur_cmd   = 1'b0;
    wr_cur_walk  = 1'b0;
    emit         = 1'b0;
    emit_idx     = pend_idx_q;
    emit_width   = pend_width_q;
    emit_last    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (msl_req_e'(req_type_i))
            REQ_SET_TARGET: begin
              wr_tgt = cmd_in_range;
            end
            REQ_PRESET: begin
              wr_tgt     = cmd_in_range;
              wr_cur_cmd = cmd_in_range;
              emit       = cmd_in_range;
              emit_idx   = cmd_idx;
              emit_width = width_value_i;
              emit_last  = 1'b1;
            end
            REQ_TICK: begin
              state_d      = ST_WALK;
              idx_d        = '0;
              pend_valid_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (moved) begin
          wr_cur_walk  = 1'b1;
          emit         = pend_valid_q;
          pend_valid_d = 1'b1;
          pend_idx_d   = idx_q;
          pend_width_d = new_width;
        end
        if (idx_q == IDX_W'(NUM_SERVOS - 1)) begin
          state_d = ST_FIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_FIN: begin
        emit         = pend_valid_q;
        emit_last    = 1'b1;
        pend_valid_d = 1'b0;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      step_q       <= STEP_RESET;
      strobe_o     <= 1'b0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        cur_q[i] <= '0;
        tgt_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      strobe_o     <= emit;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (wr_tgt) begin
        tgt_q[cmd_idx] <= width_value_i;
      end
      if (wr_cur_cmd) begin
        cur_q[cmd_idx] <= width_value_i;
      end else if (wr_cur_walk) begin
        cur_q[idx_q] <= new_width;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q    <= pend_idx_d;
    pend_width_q  <= pend_width_d;
    servo_out_o   <= SERVO_W'(emit_idx);
    pulse_width_o <= emit_width;
    last_o        <= emit_last;
  end

  // a non-final result is only given when another moved servo is being held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> pend_valid_q)
    else $error("non-final result without a held result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && pend_valid_q |=> strobe_o && last_o)
    else $error("held result not flushed as last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == REQ_TICK |=> state_q == ST_WALK && idx_q == '0 && !pend_valid_q)
    else $error("tick did not start a clean walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |=> state_q == ST_IDLE && !pend_valid_q)
    else $error("walk did not close");

endmodule

`default_nettype wire

FILE: tb/sv/multi_servo_slew_limiter_core_tb.sv
`timescale 1ns / 100ps

module multi_servo_slew_limiter_core_tb;
  import msl_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // a tick keeps busy high through its walk and flush; its last result appears once busy falls
  localparam int SETTLE_CYCLES = NUM_SERVOS + 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 16;

  typedef struct packed {
    logic [SERVO_W-1:0] servo;
    width_t             width;
    logic               last;
  } servo_update_t;

  class slew_scoreboard;
    width_t        step_size;
    width_t        cur_width[NUM_SERVOS];
    width_t        tgt_width[NUM_SERVOS];
    servo_update_t pending_updates[$];
    int            errors;

    function new();
      step_size = STEP_RESET;
      errors    = 0;
      foreach (cur_width[i]) begin
        cur_width[i] = '0;
        tgt_width[i] = '0;
      end
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [SERVO_W-1:0] servo,
                               width_t width);
      int            step;
      int            n_moving;
      int            n_done;
      int            c;
      int            t;
      servo_update_t upd;
      step = (step_size == '0) ? 1 : int'(step_size);
      case (req)
        REQ_SET_TARGET: begin
          if (servo < NUM_SERVOS) tgt_width[servo] = width;
        end
        REQ_PRESET: begin
          if (servo < NUM_SERVOS) begin
            cur_width[servo] = width;
            tgt_width[servo] = width;
            upd.servo = servo;
            upd.width = width;
            upd.last  = 1'b1;
            pending_updates.push_back(upd);
          end
        end
        REQ_TICK: begin
          n_moving = 0;
          n_done   = 0;
          for (int i = 0; i < NUM_SERVOS; i++)
            if (cur_width[i] != tgt_width[i]) n_moving++;
          for (int i = 0; i < NUM_SERVOS; i++) begin
            if (cur_width[i] != tgt_width[i]) begin
              c = int'(cur_width[i]);
              t = int'(tgt_width[i]);
              if (t > c) c = (t - c <= step) ? t : c + step;
              else c = (c - t <= step) ? t : c - step;
              cur_width[i] = width_t'(c);
              n_done++;
              upd.servo = SERVO_W'(i);
              upd.width = cur_width[i];
              upd.last  = (n_done == n_moving);
              pending_updates.push_back(upd);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_update(logic [SERVO_W-1:0] servo, width_t width, logic last);
      servo_update_t want;
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected result: servo %0d width %0d last %0b",
                 $time, servo, width, last);
        errors++;
        return;
      end
      want = pending_updates.pop_front();
      if (servo !== want.servo) begin
        $display("%0t: servo_out mismatch: expected %0d, actual %0d", $time, want.servo, servo);
        errors++;
      end
      if (width !== want.width) begin
        $display("%0t: pulse_width mismatch: expected %0d, actual %0d",
                 $time, want.width, width);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 start         = 1'b0;
  logic [REQ_W-1:0]     req_type_i    = '0;
  logic [SERVO_W-1:0]   servo_i       = '0;
  width_t               width_value_i = '0;
  logic                 cfg_we_i      = 1'b0;
  width_t               cfg_wdata_i   = '0;
  logic                 busy;
  logic                 strobe_o;
  logic [SERVO_W-1:0]   servo_out_o;
  width_t               pulse_width_o;
  logic                 last_o;

  slew_scoreboard sb = new();
  int gap_pct = 10;
  int cycles  = 0;

  always #4 clk_i = ~clk_i;

  multi_servo_slew_limiter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .servo_i       (servo_i),
    .width_value_i (width_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .strobe_o      (strobe_o),
    .servo_out_o   (servo_out_o),
    .pulse_width_o (pulse_width_o),
    .last_o        (last_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) sb.check_update(servo_out_o, pulse_width_o, last_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[multi_servo_slew_limiter_core] ERROR");
      $finish;
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [SERVO_W-1:0] servo,
                              input width_t width);
    start         <= 1'b1;
    req_type_i    <= req;
    servo_i       <= servo;
    width_value_i <= width;
    do @(posedge clk_i); while (busy);
    sb.note_request(req, servo, width);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // drain: no request in flight, nothing owed, then let any silent tick finish
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || sb.pending_updates.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step(input width_t value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.step_size = value;
  endtask

  function automatic width_t pick_width();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return width_t'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic random_phase(input int n_items);
    int n_sent;
    int r;
    n_sent = 0;
    while (n_sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_request(REQ_SET_TARGET, SERVO_W'($urandom_range(0, NUM_SERVOS - 1)), pick_width());
        n_sent++;
      end else if (r < 65) begin
        send_request(REQ_TICK, SERVO_W'($urandom_range(0, 15)), pick_width());
        n_sent++;
      end else if (r < 85) begin
        send_request(REQ_PRESET, SERVO_W'($urandom_range(0, NUM_SERVOS - 1)), pick_width());
        n_sent++;
      end else begin
        // ignored requests: bad servo index or unused code
        case ($urandom_range(0, 2))
          0: send_request(REQ_SET_TARGET, SERVO_W'($urandom_range(NUM_SERVOS, 15)),
                          pick_width());
          1: send_request(REQ_PRESET, SERVO_W'($urandom_range(NUM_SERVOS, 15)), pick_width());
          default: send_request(REQ_UNUSED, SERVO_W'($urandom_range(0, 15)), pick_width());
        endcase
        n_sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset step of 4: walk from both ends of the range
    send_request(REQ_PRESET, 4'd0, 12'd0);
    send_request(REQ_PRESET, 4'd8, 12'd4095);
    send_request(REQ_SET_TARGET, 4'd0, 12'd4095);
    send_request(REQ_SET_TARGET, 4'd8, 12'd0);
    send_request(REQ_SET_TARGET, 4'd3, 12'd10);
    send_request(REQ_TICK, 4'd0, 12'd0);
    send_request(REQ_TICK, 4'd15, 12'd4095);
    send_request(REQ_TICK, 4'd0, 12'd0);
    send_request(REQ_PRESET, 4'd9, 12'd5);
    send_request(REQ_PRESET, 4'd15, 12'd4095);
    send_request(REQ_SET_TARGET, 4'd15, 12'd4095);
    send_request(REQ_UNUSED, 4'd15, 12'd4095);
    send_request(REQ_PRESET, 4'd3, 12'd10);
    settle();

    // zero step moves by one
    write_step(12'd0);
    send_request(REQ_SET_TARGET, 4'd5, 12'd2);
    send_request(REQ_TICK, 4'd0, 12'd0);
    send_request(REQ_TICK, 4'd0, 12'd0);
    send_request(REQ_TICK, 4'd0, 12'd0);
    settle();

    // full step: every servo lands in one tick, then an idle tick
    write_step(12'd4095);
    for (int i = 0; i < NUM_SERVOS; i++)
      send_request(REQ_SET_TARGET, SERVO_W'(i), width_t'(i * 455 + 7));
    send_request(REQ_TICK, 4'd0, 12'd0);
    send_request(REQ_TICK, 4'd0, 12'd0);
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       write_step(12'd1);
        1:       write_step(width_t'($urandom_range(2, 64)));
        2:       write_step(12'd4095);
        3:       write_step(12'd0);
        default: write_step(width_t'($urandom_range(2, 400)));
      endcase
      gap_pct = (phase == 2) ? 0 : 10;
      random_phase(PHASE_ITEMS);
      settle();
    end

    if (sb.errors == 0) begin
      $display("[multi_servo_slew_limiter_core] OK");
    end else begin
      $display("[multi_servo_slew_limiter_core] ERROR");
    end
    $finish;
  end

endmodule
